// ===== rtl/lu_doolittle_linear_solver_defines.svh =====
// Assertion macros shared by the LU solver RTL.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef LU_DOOLITTLE_LINEAR_SOLVER_DEFINES_SVH
`define LU_DOOLITTLE_LINEAR_SOLVER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LUDLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("LU solver assertion failed");
// Next-cycle implication.
`define LUDLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("LU solver assertion failed");
`else
`define LUDLS_ASSERT_NOW(lbl, ante, cons)
`define LUDLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ludls_pkg.sv =====
// Shared types and constants of the LU linear solver.
// No dependencies; imported by every module of the block but ludls_ram.
`timescale 1ns / 1ps
package ludls_pkg;

  // Reset value of the system order register.
  localparam logic [3:0] SIZE_RESET = 4'd8;

  // Depth of the command queue between front and engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One load item as it arrives.
  typedef struct packed {
    logic               mode;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               start_req;
  } in_item_t;

  // One solution element as it leaves.
  typedef struct packed {
    logic [2:0]         index;
    logic signed [31:0] solution;
    logic               singular;
    logic               last;
  } out_item_t;

  // A classified load item: which store it goes to, and whether a solve follows.
  typedef struct packed {
    logic               wr_a;
    logic               wr_b;
    logic               start;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } cmd_t;

  // Request to the serial divider.
  typedef struct packed {
    logic               start;
    logic signed [47:0] num;
    logic signed [31:0] den;
  } div_req_t;

  // Answer of the serial divider.
  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/lu_doolittle_linear_solver.sv =====
// Doolittle LU linear solver, top level. Ties the front end, command queue,
// solve engine and serial divider together. Depends on ludls_pkg and all rtl modules.
`timescale 1ns / 1ps
// Load items enter at up to one per cycle while in_stall_o is low, and are drained from
// the queue one per cycle while the engine is idle. An item with start_req runs the solve
// on the order held in size_q: each product term passes through ST_RD, ST_MUL and ST_ACC
// on the single 32x32 multiplier, and each element of L and of x waits on the bit-serial divider.
// The n solution elements then leave through the output register while out_stall_i is low.
// A is factored in place and must be loaded again before the next solve; no
// clearing pass is needed after reset.
`include "lu_doolittle_linear_solver_defines.svh"
module lu_doolittle_linear_solver import ludls_pkg::*; #(
  parameter int MAX_ORDER = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic [3:0] size_q;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       q_in, q_out;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // Order register; always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  ludls_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .push_o(q_push), .cmd_o(q_in), .full_i(q_full)
  );

  ludls_fifo u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .data_o(q_out), .empty_o(q_empty)
  );

  ludls_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  ludls_engine #(.MAX_ORDER(MAX_ORDER)) u_engine (
    .clk_i, .rst_ni, .size_i(size_q), .cmd_i(q_out), .cmd_valid_i(!q_empty),
    .cmd_pop_o(q_pop), .div_req_o(div_req), .div_rsp_i(div_rsp),
    .out_valid_o, .out_stall_i, .out_item_o
  );

  // The queue never overflows or underflows, and a quotient is reported once.
  `LUDLS_ASSERT_NOW(a_push_room, q_push, !q_full)
  `LUDLS_ASSERT_NOW(a_pop_data, q_pop, !q_empty)
  `LUDLS_ASSERT_NEXT(a_div_once, div_rsp.done, !div_rsp.done)

endmodule

// ===== rtl/ludls_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ludls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ludls_front.sv =====
// Front end: takes load items, checks their indexes and classifies them.
// Depends on ludls_pkg; feeds ludls_fifo.
`timescale 1ns / 1ps
module ludls_front import ludls_pkg::*; #(
  parameter int MAX_ORDER = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output cmd_t     cmd_o,
  input  logic     full_i
);

  logic hold_valid_q, hold_valid_d;
  cmd_t hold_q;
  logic accept;
  logic row_ok, col_ok;

  // Stall only when the holding register is full and cannot drain.
  assign in_stall_o = hold_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = hold_valid_q && !full_i;
  assign cmd_o      = hold_q;

  // Entries outside the store are dropped but may still start a solve.
  assign row_ok = 32'(in_item_i.row) < MAX_ORDER;
  assign col_ok = 32'(in_item_i.col) < MAX_ORDER;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (push_o) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  // Classified item register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q.wr_a  <= !in_item_i.mode && row_ok && col_ok;
      hold_q.wr_b  <= in_item_i.mode && row_ok;
      hold_q.start <= in_item_i.start_req;
      hold_q.row   <= in_item_i.row;
      hold_q.col   <= in_item_i.col;
      hold_q.value <= in_item_i.value;
    end
  end

endmodule

// ===== rtl/ludls_fifo.sv =====
// Short command queue between the front end and the solve engine.
// Depends on ludls_pkg.
`timescale 1ns / 1ps
module ludls_fifo import ludls_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/ludls_div.sv =====
// Serial restoring divider: (num * 2^16) / den, truncated toward zero,
// saturated to signed 32 bits. One quotient bit per cycle. Depends on ludls_pkg.
`timescale 1ns / 1ps
module ludls_div import ludls_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [6:0]  cnt_q;
  logic        neg_q;
  logic [63:0] q_q;
  logic [32:0] rem_q;
  logic [31:0] d_q;
  logic [47:0] num_abs;
  logic [31:0] den_abs;
  logic [32:0] rem_sh;
  logic        ge;

  assign num_abs = req_i.num[47] ? (~req_i.num + 48'd1) : req_i.num;
  assign den_abs = req_i.den[31] ? (~req_i.den + 32'd1) : req_i.den;

  // One restoring step.
  assign rem_sh = {rem_q[31:0], q_q[63]};
  assign ge     = rem_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q   <= {num_abs, 16'd0};
      rem_q <= '0;
      d_q   <= den_abs;
      neg_q <= req_i.num[47] ^ req_i.den[31];
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
      q_q   <= {q_q[62:0], ge};
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.quot = (q_q > 64'd2147483648) ? 32'sh80000000 : (~q_q[31:0] + 32'd1);
    end else begin
      rsp_o.quot = (q_q > 64'd2147483647) ? 32'sh7fffffff : q_q[31:0];
    end
  end

endmodule

// ===== rtl/ludls_engine.sv =====
// Solve engine: stores loads, factors A in place, substitutes, emits x.
// Depends on ludls_pkg and ludls_ram; uses the divider through div_req_o/div_rsp_i.
`timescale 1ns / 1ps
module ludls_engine import ludls_pkg::*; #(
  parameter int MAX_ORDER = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] size_i,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_pop_o,
  output div_req_t   div_req_o,
  input  div_rsp_t   div_rsp_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  localparam int AW  = $clog2(MAX_ORDER);
  localparam int FAW = $clog2(MAX_ORDER * MAX_ORDER);
  localparam int CW  = $clog2(MAX_ORDER + 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TASK = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_ENT  = 4'd5;
  localparam logic [3:0] ST_DIF  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_NEXT = 4'd8;
  localparam logic [3:0] ST_CHK0 = 4'd9;
  localparam logic [3:0] ST_CHK1 = 4'd10;
  localparam logic [3:0] ST_EMRD = 4'd11;
  localparam logic [3:0] ST_EMWR = 4'd12;

  // Element operations.
  localparam logic [1:0] OP_U = 2'd0;  // row of U
  localparam logic [1:0] OP_L = 2'd1;  // column of L
  localparam logic [1:0] OP_F = 2'd2;  // forward substitution
  localparam logic [1:0] OP_B = 2'd3;  // back substitution

  localparam logic signed [56:0] MAX32 = 57'sd2147483647;
  localparam logic signed [56:0] MIN32 = -57'sd2147483648;
  localparam logic signed [56:0] LIM48 = 57'sd140737488355327;

  function automatic logic [FAW-1:0] faddr(input logic [AW-1:0] r, input logic [AW-1:0] c);
    faddr = FAW'(r) * FAW'(MAX_ORDER) + FAW'(c);
  endfunction

  logic [3:0]  state_q, state_d;
  logic [1:0]  op_q, op_d;
  logic [CW-1:0] k_q, k_d, x_q, x_d, t_q, t_d, n_q, n_d;
  logic        sing_q, sing_d;
  logic signed [55:0] acc_q, acc_d;
  logic signed [63:0] prod_q;
  logic        out_valid_q, out_valid_d, out_load;
  out_item_t   out_item_q;

  logic [CW-1:0] r_idx, c_idx, piv_idx, t_start, t_end, n_new;
  logic [FAW-1:0] fa_raddr, fb_raddr, f_waddr;
  logic [AW-1:0]  s_raddr, s_waddr, h_waddr;
  logic [31:0]    fa_rdata, fb_rdata, s_rdata, h_rdata, f_wdata, s_wdata;
  logic           f_we, s_we, h_we;
  logic signed [31:0] opb, entry;
  logic signed [63:0] prod_adj;
  logic signed [47:0] term;
  logic signed [56:0] diff, diff48;
  logic signed [31:0] diff32;
  logic           adv_k;

  // Factor store, kept twice so two entries can be read per cycle.
  ludls_ram #(.WIDTH(32), .DEPTH(MAX_ORDER * MAX_ORDER)) u_fa (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(fa_raddr), .rdata_o(fa_rdata)
  );
  ludls_ram #(.WIDTH(32), .DEPTH(MAX_ORDER * MAX_ORDER)) u_fb (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(fb_raddr), .rdata_o(fb_rdata)
  );
  // Solution store: z, then x.
  ludls_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_sol (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );
  // Right-hand side store.
  ludls_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_rhs (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(cmd_i.value),
    .raddr_i(AW'(r_idx)), .rdata_o(h_rdata)
  );

  // Row, column and term range of the current element.
  always_comb begin
    r_idx   = x_q;
    c_idx   = k_q;
    t_start = '0;
    t_end   = k_q;
    piv_idx = x_q;
    case (op_q)
      OP_U: begin
        r_idx = k_q;
        c_idx = x_q;
      end
      OP_L: begin
        piv_idx = k_q;
      end
      OP_F: begin
        t_end = x_q;
      end
      OP_B: begin
        t_start = x_q + CW'(1);
        t_end   = n_q;
      end
      default: begin
        t_end = k_q;
      end
    endcase
  end

  // Order actually solved.
  always_comb begin
    if (size_i == 4'd0) begin
      n_new = CW'(1);
    end else if (32'(size_i) > MAX_ORDER) begin
      n_new = CW'(MAX_ORDER);
    end else begin
      n_new = CW'(size_i);
    end
  end

  // Read addresses per state.
  always_comb begin
    fa_raddr = faddr(AW'(r_idx), AW'(c_idx));
    fb_raddr = faddr(AW'(piv_idx), AW'(piv_idx));
    s_raddr  = AW'(r_idx);
    case (state_q)
      ST_RD: begin
        fa_raddr = faddr(AW'(r_idx), AW'(t_q));
        fb_raddr = faddr(AW'(t_q), AW'(c_idx));
        s_raddr  = AW'(t_q);
      end
      ST_CHK0: begin
        fb_raddr = faddr(AW'(k_q), AW'(k_q));
      end
      ST_EMRD, ST_EMWR: begin
        s_raddr = AW'(x_q);
      end
      default: begin
        s_raddr = AW'(r_idx);
      end
    endcase
  end

  // Operand selection and fixed-point arithmetic.
  assign opb      = (op_q == OP_U || op_q == OP_L) ? fb_rdata : s_rdata;
  assign prod_adj = prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0);
  assign term     = prod_adj[63:16];

  always_comb begin
    case (op_q)
      OP_U, OP_L: entry = fa_rdata;
      OP_F:       entry = h_rdata;
      default:    entry = s_rdata;
    endcase
  end

  assign diff = {{25{entry[31]}}, entry} - {acc_q[55], acc_q};

  // Saturation to 32 bits and clamping to 48 bits.
  always_comb begin
    if (diff > MAX32) begin
      diff32 = 32'sh7fffffff;
    end else if (diff < MIN32) begin
      diff32 = 32'sh80000000;
    end else begin
      diff32 = diff[31:0];
    end
    if (diff > LIM48) begin
      diff48 = LIM48;
    end else if (diff < -LIM48) begin
      diff48 = -LIM48;
    end else begin
      diff48 = diff;
    end
  end

  // Main sequencer.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    k_d       = k_q;
    x_d       = x_q;
    t_d       = t_q;
    n_d       = n_q;
    sing_d    = sing_q;
    acc_d     = acc_q;
    cmd_pop_o = 1'b0;
    f_we      = 1'b0;
    f_waddr   = faddr(AW'(r_idx), AW'(c_idx));
    f_wdata   = diff32;
    s_we      = 1'b0;
    s_waddr   = AW'(r_idx);
    s_wdata   = diff32;
    h_we      = 1'b0;
    h_waddr   = AW'(cmd_i.row);
    div_req_o.start = 1'b0;
    div_req_o.num   = diff48[47:0];
    div_req_o.den   = fb_rdata;
    out_load  = 1'b0;
    adv_k     = 1'b0;

    case (state_q)
      // Store loads; a start item launches the solve.
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          f_we      = cmd_i.wr_a;
          f_waddr   = faddr(AW'(cmd_i.row), AW'(cmd_i.col));
          f_wdata   = cmd_i.value;
          h_we      = cmd_i.wr_b;
          if (cmd_i.start) begin
            n_d     = n_new;
            k_d     = '0;
            x_d     = '0;
            op_d    = OP_U;
            sing_d  = 1'b0;
            state_d = ST_TASK;
          end
        end
      end
      ST_TASK: begin
        t_d     = t_start;
        acc_d   = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = (t_q == t_end) ? ST_ENT : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_q + {{8{term[47]}}, term};
        t_d     = t_q + CW'(1);
        state_d = ST_RD;
      end
      ST_ENT: begin
        state_d = ST_DIF;
      end
      // Elements of U and z are written directly; L and x go through the divider.
      ST_DIF: begin
        case (op_q)
          OP_U: begin
            f_we    = 1'b1;
            state_d = ST_NEXT;
          end
          OP_F: begin
            s_we    = 1'b1;
            state_d = ST_NEXT;
          end
          default: begin
            div_req_o.start = 1'b1;
            state_d         = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        f_wdata = div_rsp_i.quot;
        s_wdata = div_rsp_i.quot;
        if (div_rsp_i.done) begin
          f_we    = op_q == OP_L;
          s_we    = op_q == OP_B;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_d = ST_TASK;
        case (op_q)
          OP_U: begin
            if (x_q + CW'(1) == n_q) begin
              state_d = ST_CHK0;
            end else begin
              x_d = x_q + CW'(1);
            end
          end
          OP_L: begin
            if (x_q + CW'(1) == n_q) begin
              adv_k = 1'b1;
            end else begin
              x_d = x_q + CW'(1);
            end
          end
          OP_F: begin
            if (x_q + CW'(1) == n_q) begin
              op_d = OP_B;
            end else begin
              x_d = x_q + CW'(1);
            end
          end
          default: begin
            if (x_q == '0) begin
              state_d = ST_EMRD;
            end else begin
              x_d = x_q - CW'(1);
            end
          end
        endcase
      end
      ST_CHK0: begin
        state_d = ST_CHK1;
      end
      // Pivot check: a zero pivot skips this column of L.
      ST_CHK1: begin
        if (fb_rdata == '0) begin
          sing_d = 1'b1;
          adv_k  = 1'b1;
        end else if (k_q + CW'(1) == n_q) begin
          adv_k = 1'b1;
        end else begin
          op_d    = OP_L;
          x_d     = k_q + CW'(1);
          state_d = ST_TASK;
        end
      end
      ST_EMRD: begin
        state_d = ST_EMWR;
      end
      // Hand one element to the output register when it is free.
      ST_EMWR: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (x_q + CW'(1) == n_q) begin
            state_d = ST_IDLE;
          end else begin
            x_d     = x_q + CW'(1);
            state_d = ST_EMRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Step to the next pivot; after the last one, on to substitution, or straight to output if a pivot was zero.
    if (adv_k) begin
      if (k_q + CW'(1) == n_q) begin
        x_d     = '0;
        op_d    = OP_F;
        state_d = sing_d ? ST_EMRD : ST_TASK;
      end else begin
        k_d     = k_q + CW'(1);
        x_d     = k_q + CW'(1);
        op_d    = OP_U;
        state_d = ST_TASK;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_U;
      k_q         <= '0;
      x_q         <= '0;
      t_q         <= '0;
      n_q         <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      x_q         <= x_d;
      t_q         <= t_d;
      n_q         <= n_d;
      sing_q      <= sing_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= $signed(fa_rdata) * opb;
    if (out_load) begin
      out_item_q.index    <= 3'(x_q);
      out_item_q.solution <= sing_q ? 32'sd0 : s_rdata;
      out_item_q.singular <= sing_q;
      out_item_q.last     <= x_q + CW'(1) == n_q;
    end
  end

endmodule

// ===== verif/lu_solver_checker.sv =====
// Checker for the LU linear solver: watches the three channels, predicts the solution items
// and compares them with what the block emits. Depends on ludls_pkg.
`timescale 1ns / 1ps
module lu_solver_checker import ludls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [3:0] cfg_data_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        err_cnt_o,
  output int        pending_o
);

  localparam int ORDER_MAX = 8;
  localparam longint ONE_Q = 64'sd65536;
  localparam longint CLIP48 = 64'sd140737488355327;

  logic signed [31:0] lu_mem [ORDER_MAX*ORDER_MAX];
  logic signed [31:0] rhs_mem [ORDER_MAX];
  logic signed [31:0] x_mem [ORDER_MAX];
  logic [3:0]         order_reg;
  out_item_t          solution_q [$];

  assign pending_o = solution_q.size();

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    return (longint'(a) * longint'(b)) / ONE_Q;
  endfunction

  function automatic longint clip48(longint v);
    if (v > CLIP48) return CLIP48;
    if (v < -CLIP48) return -CLIP48;
    return v;
  endfunction

  function automatic logic signed [31:0] fx_div(longint d, logic signed [31:0] den);
    return sat32((clip48(d) * ONE_Q) / longint'(den));
  endfunction

  // Factor in place, substitute forward and back, and queue the n solution items.
  task automatic predict_solution();
    int n;
    bit sing;
    longint s;
    out_item_t r;
    n = (order_reg == 0) ? 1 : (order_reg > ORDER_MAX) ? ORDER_MAX : int'(order_reg);
    sing = 0;
    for (int k = 0; k < n; k++) begin
      for (int j = k; j < n; j++) begin
        s = 0;
        for (int p = 0; p < k; p++) s += fx_mul(lu_mem[k*ORDER_MAX+p], lu_mem[p*ORDER_MAX+j]);
        lu_mem[k*ORDER_MAX+j] = sat32(clip48(longint'(lu_mem[k*ORDER_MAX+j]) - s));
      end
      if (lu_mem[k*ORDER_MAX+k] == 0) begin
        sing = 1;
        continue;
      end
      for (int i = k + 1; i < n; i++) begin
        s = 0;
        for (int p = 0; p < k; p++) s += fx_mul(lu_mem[i*ORDER_MAX+p], lu_mem[p*ORDER_MAX+k]);
        lu_mem[i*ORDER_MAX+k] = fx_div(longint'(lu_mem[i*ORDER_MAX+k]) - s,
                                       lu_mem[k*ORDER_MAX+k]);
      end
    end
    if (!sing) begin
      for (int i = 0; i < n; i++) begin
        s = 0;
        for (int p = 0; p < i; p++) s += fx_mul(lu_mem[i*ORDER_MAX+p], x_mem[p]);
        x_mem[i] = sat32(clip48(longint'(rhs_mem[i]) - s));
      end
      for (int i = n - 1; i >= 0; i--) begin
        s = 0;
        for (int j = i + 1; j < n; j++) s += fx_mul(lu_mem[i*ORDER_MAX+j], x_mem[j]);
        x_mem[i] = fx_div(longint'(x_mem[i]) - s, lu_mem[i*ORDER_MAX+i]);
      end
    end
    for (int i = 0; i < n; i++) begin
      r.index    = 3'(i);
      r.solution = sing ? 32'sd0 : x_mem[i];
      r.singular = sing;
      r.last     = (i == n - 1);
      solution_q.push_back(r);
    end
  endtask

  // Track register writes, load items and solution items on each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      order_reg = SIZE_RESET;
      err_cnt_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) order_reg = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.mode) rhs_mem[in_item_i.row] = in_item_i.value;
        else lu_mem[in_item_i.row*ORDER_MAX+in_item_i.col] = in_item_i.value;
        if (in_item_i.start_req) predict_solution();
      end
      if (out_valid_i && !out_stall_i) begin
        if (solution_q.size() == 0) begin
          $display("%0t: unexpected solution item, got %p", $time, out_item_i);
          err_cnt_o++;
        end else begin
          exp_item = solution_q.pop_front();
          if (out_item_i.index !== exp_item.index || out_item_i.solution !== exp_item.solution ||
              out_item_i.singular !== exp_item.singular || out_item_i.last !== exp_item.last) begin
            $display("%0t: solution mismatch, expected %p, actual %p",
                     $time, exp_item, out_item_i);
            err_cnt_o++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_lu_doolittle_linear_solver.sv =====
// Testbench top for the LU linear solver: drives register writes, load items and output
// stalls, and gives the verdict. Depends on ludls_pkg, lu_solver_checker and the RTL.
`timescale 1ns / 1ps
module tb_lu_doolittle_linear_solver;
  import ludls_pkg::*;

  localparam int WATCH_LIMIT = 50000;
  localparam int HOLD_CYCLES = 2500;

  // Kinds of system that one load sequence builds.
  typedef enum int {SYS_DOMINANT, SYS_FULL_RANGE, SYS_SINGULAR, SYS_EXTREME} sys_kind_e;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      cfg_valid_i = 0;
  logic      cfg_ready_o;
  logic [3:0] cfg_data_i = '0;
  logic      in_valid_i = 0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 0;
  out_item_t out_item_o;
  int        err_cnt, pending;
  bit        idle_on = 1;
  bit        hold_go = 0;
  int        solve_cnt = 0;
  int        item_cnt = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  lu_doolittle_linear_solver uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_item_i, .out_valid_o, .out_stall_i, .out_item_o
  );

  lu_solver_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // Receiver: random stalls, plus one long hold-off so that the block backs up.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 99) < 31);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("[lu_doolittle_linear_solver] ERROR");
        $finish;
      end
    end
  end

  // Offer one item, sometimes after a random gap, and wait until it is taken.
  task automatic send_item(in_item_t it);
    if (idle_on && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    item_cnt++;
  endtask

  // Write the order register once the block is idle.
  task automatic write_order(logic [3:0] v);
    in_valid_i <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  function automatic logic signed [31:0] entry_value(sys_kind_e kind, bit diag);
    logic signed [31:0] v;
    case (kind)
      SYS_DOMINANT: begin
        if (diag) v = $urandom_range(4 << 16, 64 << 16);
        else v = $signed($urandom_range(0, 1 << 17)) - 32'sd65536;
        if ($urandom_range(0, 1)) v = -v;
      end
      SYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = 32'sh00010000;
          default: v = 32'sh00000001;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Load a full system of order n in random order; the last item starts the solve.
  task automatic load_system(int n, sys_kind_e kind, int noise);
    in_item_t seq [$];
    in_item_t it, tmp;
    int j;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        it = '0;
        it.row = 3'(r);
        it.col = 3'(c);
        it.value = entry_value(kind, r == c);
        if (kind == SYS_SINGULAR && r == 1) it.value = seq[c].value;
        if (kind == SYS_SINGULAR && n == 1) it.value = '0;
        seq.push_back(it);
      end
    end
    for (int r = 0; r < n; r++) begin
      it = '0;
      it.mode = 1;
      it.row = 3'(r);
      it.col = 3'($urandom_range(0, 7));
      it.value = (kind == SYS_EXTREME) ? entry_value(kind, 0) : 32'($urandom);
      seq.push_back(it);
    end
    // Writes outside the active order are stored but never used by the solve.
    for (int k = 0; k < noise && n < 8; k++) begin
      it = '0;
      it.mode = $urandom_range(0, 1);
      it.row = 3'($urandom_range(n, 7));
      it.col = 3'($urandom_range(0, 7));
      it.value = $urandom;
      seq.push_back(it);
    end
    for (int i = seq.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = seq[i];
      seq[i] = seq[j];
      seq[j] = tmp;
    end
    seq[seq.size() - 1].start_req = 1;
    foreach (seq[i]) send_item(seq[i]);
    solve_cnt++;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: order zero acts as one, zero pivot, extreme values, singular 2x2.
    write_order(4'd0);
    load_system(1, SYS_SINGULAR, 0);
    load_system(1, SYS_EXTREME, 0);
    write_order(4'd2);
    load_system(2, SYS_EXTREME, 0);
    load_system(2, SYS_SINGULAR, 0);

    // Random: several orders, with a long receiver hold-off during back-to-back solves.
    write_order(4'd3);
    hold_go = 1;
    load_system(3, SYS_DOMINANT, $urandom_range(0, 2));
    load_system(3, SYS_FULL_RANGE, 1);
    write_order(4'd1);
    repeat (3) load_system(1, sys_kind_e'($urandom_range(0, 2)), $urandom_range(0, 2));
    write_order(4'd15);
    idle_on = 0;
    load_system(8, SYS_DOMINANT, 0);
    idle_on = 1;
    write_order(4'd4);
    load_system(4, SYS_EXTREME, 0);
    load_system(4, SYS_SINGULAR, 0);
    write_order(4'd2);
    load_system(2, sys_kind_e'($urandom_range(0, 3)), $urandom_range(0, 3));

    in_valid_i <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d solves from %0d load items over orders 1 to 8,", solve_cnt, item_cnt);
    $display("including singular, saturating and back-pressured systems.");
    if (err_cnt == 0 && pending == 0) begin
      $display("[lu_doolittle_linear_solver] OK");
    end else begin
      $display("[lu_doolittle_linear_solver] ERROR");
    end
    $finish;
  end

endmodule
